FILE: hw/rtl/fbpc_pkg.sv
// shared types and constants for the frustum cull block
`default_nettype none
package fbpc_pkg;
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_REGS   = 8;
  localparam int REG_BITS   = 64;
  localparam int IDX_BITS   = 3;
  localparam int COEF_BITS  = 33;
  localparam int PROD_BITS  = 66;
  localparam int ACC_BITS   = 69;
  localparam int NUM_PLANES = 6;

  localparam logic REQ_BOX   = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0] acc_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } plane_t;

  localparam logic [REG_BITS-1:0] MAT_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };
endpackage
`default_nettype wire

FILE: hw/rtl/fbpc_planes.sv
// matrix registers and plane coefficient build
`default_nettype none
module fbpc_planes (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [fbpc_pkg::IDX_BITS-1:0]       cfg_index,
  input  wire logic [fbpc_pkg::REG_BITS-1:0]       cfg_data,
  output fbpc_pkg::plane_t                         planes [fbpc_pkg::NUM_PLANES]
);
  logic [fbpc_pkg::REG_BITS-1:0] mat [fbpc_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbpc_pkg::NUM_REGS; i++) mat[i] <= fbpc_pkg::MAT_RESET[i];
    end else if (cfg_we) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  function automatic fbpc_pkg::coef_t ent(input logic [fbpc_pkg::REG_BITS-1:0] r,
                                          input logic hi);
    logic [31:0] w;
    w = hi ? r[63:32] : r[31:0];
    return fbpc_pkg::coef_t'($signed(w));
  endfunction

  // plane 2k+s = col3 +/- col k, registered
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < 2; s++) begin
        fbpc_pkg::coef_t c3 [4];
        fbpc_pkg::coef_t ck [4];
        fbpc_pkg::coef_t r  [4];
        for (int i = 0; i < 4; i++) begin
          c3[i] = ent(mat[2*i+1], 1'b1);
          ck[i] = ent(mat[2*i + k/2], k[0]);
          r[i]  = (s != 0) ? c3[i] - ck[i] : c3[i] + ck[i];
        end
        planes[2*k+s] <= '{a: r[0], b: r[1], c: r[2], d: r[3]};
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/fbpc_plane_eval.sv
// one plane test as a three stage pipeline: corner pick, products, sum and sign
`default_nettype none
module fbpc_plane_eval (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             point,
  input  fbpc_pkg::coord_t      lo [3],
  input  fbpc_pkg::coord_t      hi [3],
  input  fbpc_pkg::plane_t      pl,
  output logic                  front
);
  fbpc_pkg::coef_t  cf [3];
  fbpc_pkg::coord_t p  [3];
  fbpc_pkg::coef_t  d1;
  fbpc_pkg::prod_t  pr [4];
  fbpc_pkg::acc_t   sum;

  always_comb begin
    cf[0] = pl.a; cf[1] = pl.b; cf[2] = pl.c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fbpc_pkg::coord_t big, sml;
        big = (lo[i] > hi[i]) ? lo[i] : hi[i];
        sml = (lo[i] > hi[i]) ? hi[i] : lo[i];
        p[i] <= point ? lo[i] : (cf[i] >= 0 ? big : sml);
      end
      for (int i = 0; i < 3; i++) begin
        pr[i] <= fbpc_pkg::prod_t'(cf[i]) * fbpc_pkg::prod_t'(p[i]);
      end
      d1 <= pl.d;
      pr[3] <= fbpc_pkg::prod_t'({{(fbpc_pkg::PROD_BITS-fbpc_pkg::COEF_BITS
                 -fbpc_pkg::FRAC_BITS){d1[fbpc_pkg::COEF_BITS-1]}}, d1,
                 {fbpc_pkg::FRAC_BITS{1'b0}}});
      sum <= fbpc_pkg::acc_t'(pr[0]) + fbpc_pkg::acc_t'(pr[1])
           + fbpc_pkg::acc_t'(pr[2]) + fbpc_pkg::acc_t'(pr[3]);
    end
  end

  assign front = (sum > 0);
endmodule
`default_nettype wire

FILE: hw/rtl/frustum_box_point_cull.sv
// frustum_box_point_cull: fixed-point frustum culling of boxes and points
// input item on s_axis: req_type selects box (0) or point (1) test with
// corners x0..z1; one visible bit per item comes out on m_axis in order.
// matrix is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while idle, not enforced by the block. index 0..7 per register. reset
// loads the identity matrix. the six planes are formed from the matrix into
// registers, so s_axis_tready stays low for the cycle after a write and the
// next item sees the new planes. throughput: one item per cycle while
// s_axis_tready is high. each item passes the corner pick, product, sum
// and output registers before tvalid. when m_axis_tvalid is high and
// m_axis_tready is low the whole pipeline holds; s_axis_tready is high
// whenever the output register is empty or being taken and cfg_wait is
// clear, so the pipeline never drops or repeats an item.
`default_nettype none
module frustum_box_point_cull (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [191:0] s_axis_tdata,  // x0, y0, z0, x1, y1, z1
  input  wire logic         s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // visible
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  fbpc_pkg::plane_t planes [fbpc_pkg::NUM_PLANES];
  fbpc_pkg::coord_t lo [3];
  fbpc_pkg::coord_t hi [3];
  logic [fbpc_pkg::NUM_PLANES-1:0] front;
  logic [2:0] vld;
  logic en;
  logic cfg_wait;

  fbpc_planes u_planes (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .planes(planes)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo[i] = fbpc_pkg::coord_t'(s_axis_tdata[32*i +: 32]);
      hi[i] = fbpc_pkg::coord_t'(s_axis_tdata[96+32*i +: 32]);
    end
  end

  // plane registers catch up in the cycle after a matrix write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_wait <= 1'b0;
    end else begin
      cfg_wait <= cfg_we;
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !cfg_wait;

  for (genvar g = 0; g < fbpc_pkg::NUM_PLANES; g++) begin : g_pl
    fbpc_plane_eval u_eval (
      .clk(clk), .en(en), .point(s_axis_tuser == fbpc_pkg::REQ_POINT),
      .lo(lo), .hi(hi), .pl(planes[g]), .front(front[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld <= {vld[1:0], s_axis_tvalid && s_axis_tready};
      m_axis_tvalid <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= {7'b0, &front};
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && !cfg_wait |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    en && vld[2] |=> m_axis_tvalid)
    else $error("item lost at output");
`endif
endmodule
`default_nettype wire

FILE: test/frustum_cull_checker.sv
// checker for the frustum cull block: predicts visibility and compares results
`timescale 1ns / 100ps
module frustum_cull_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [191:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [7:0]   m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  output int                fail_count,
  output int                pending
);
  logic [fbpc_pkg::REG_BITS-1:0] matrix [fbpc_pkg::NUM_REGS];
  logic [7:0] visible_q [$];

  function automatic logic signed [32:0] entry(int r, int c);
    logic [63:0] word;
    word = matrix[r * 2 + c / 2];
    return (c % 2) ? $signed(word[63:32]) : $signed(word[31:0]);
  endfunction

  function automatic logic predict_visible(logic point, logic [191:0] d);
    logic signed [32:0] lo [3];
    logic signed [32:0] hi [3];
    logic signed [32:0] co [4];
    logic signed [32:0] p;
    logic signed [127:0] sum;
    logic vis;
    vis = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lo[i] = $signed(d[32*i +: 32]);
      hi[i] = $signed(d[32*(i+3) +: 32]);
    end
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < 4; i++)
          co[i] = s ? entry(i, 3) - entry(i, k) : entry(i, 3) + entry(i, k);
        sum = 128'(co[3]) <<< fbpc_pkg::FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
          if (point) p = lo[i];
          else if (co[i] >= 0) p = (lo[i] > hi[i]) ? lo[i] : hi[i];
          else p = (lo[i] > hi[i]) ? hi[i] : lo[i];
          sum = sum + 128'(co[i]) * 128'(p);
        end
        if (sum <= 0) vis = 1'b0;
      end
    end
    return vis;
  endfunction

  assign pending = visible_q.size();

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbpc_pkg::NUM_REGS; i++) matrix[i] <= fbpc_pkg::MAT_RESET[i];
      visible_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) matrix[cfg_index] <= cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        visible_q.push_back({7'd0, predict_visible(s_axis_tuser, s_axis_tdata)});
      if (m_axis_tvalid && m_axis_tready) begin
        if (visible_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          if (visible_q[0] !== m_axis_tdata) begin
            if (fail_count < 10)
              $display("visible mismatch: expected %h got %h", visible_q[0], m_axis_tdata);
            fail_count <= fail_count + 1;
          end
          void'(visible_q.pop_front());
        end
      end
    end
  end
endmodule

FILE: test/frustum_box_point_cull_tb.sv
// testbench top: drives boxes, points and matrices into the cull block
`timescale 1ns / 100ps
module frustum_box_point_cull_tb;
  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [191:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;
  int fail_count, pending;
  int cycle_count = 0;
  bit hold_long, quiet_end;

  frustum_box_point_cull dut (.*);
  frustum_cull_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        m_axis_tready <= 0;
        repeat (60) @(negedge clk);
        hold_long = 0;
      end
      if (!quiet_end && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 32'h000c_0000) - 32'h0006_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endcase
  endfunction

  task automatic send(logic kind, logic [191:0] data);
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (!quiet_end && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [63:0] value);
    cfg_we <= 1;
    cfg_index <= idx[2:0];
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic random_items(int n);
    logic [191:0] d;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 6; j++) d[32*j +: 32] = rand_coord();
      send($urandom_range(0, 1) ? fbpc_pkg::REQ_POINT : fbpc_pkg::REQ_BOX, d);
    end
  endtask

  initial begin
    hold_long = 0;
    quiet_end = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tuser = fbpc_pkg::REQ_BOX;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: identity matrix, extremes, swapped bounds, points
    send(fbpc_pkg::REQ_POINT, '0);
    send(fbpc_pkg::REQ_POINT, {96'd0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000});
    send(fbpc_pkg::REQ_POINT, {96'd0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000});
    send(fbpc_pkg::REQ_POINT, {96'hffff_ffff_ffff_ffff_ffff_ffff, 32'hffff_8000,
                               32'h0, 32'h0});
    send(fbpc_pkg::REQ_BOX, {32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                             32'hffff_8000, 32'hffff_8000, 32'hffff_8000});
    send(fbpc_pkg::REQ_BOX, {32'h0003_0000, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'h0});
    send(fbpc_pkg::REQ_BOX, {32'h0002_0000, 32'h0, 32'h0, 32'h0003_0000, 32'h0, 32'h0});
    send(fbpc_pkg::REQ_BOX, {3{32'h7fff_ffff, 32'h8000_0000}});
    send(fbpc_pkg::REQ_BOX, {6{32'h8000_0000}});
    send(fbpc_pkg::REQ_BOX, {6{32'h7fff_ffff}});
    send(fbpc_pkg::REQ_POINT, {6{32'h8000_0000}});
    send(fbpc_pkg::REQ_POINT, {6{32'h7fff_ffff}});
    drain();

    // degenerate plane: zero matrix hides everything
    for (int r = 0; r < fbpc_pkg::NUM_REGS; r++) write_reg(r, 64'd0);
    send(fbpc_pkg::REQ_POINT, '0);
    send(fbpc_pkg::REQ_BOX, {6{32'h1234_5678}});
    drain();
    // all extremes in the matrix
    for (int r = 0; r < fbpc_pkg::NUM_REGS; r++) write_reg(r, 64'h7fff_ffff_8000_0000);
    random_items(10);
    drain();
    for (int r = 0; r < fbpc_pkg::NUM_REGS; r++) write_reg(r, 64'hffff_ffff_ffff_ffff);
    random_items(10);
    drain();

    // random phases, the first with the identity matrix, the rest with random matrices
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        for (int r = 0; r < fbpc_pkg::NUM_REGS; r++) write_reg(r, fbpc_pkg::MAT_RESET[r]);
      end else begin
        for (int r = 0; r < fbpc_pkg::NUM_REGS; r++)
          write_reg(r, {rand_entry(), rand_entry()});
      end
      if (ph == 3) hold_long = 1;
      if (ph == 11) quiet_end = 1;
      random_items(110);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
